[design/drle_pkg.sv]
// Shared types and constants for the depth run-length encoder.
// Used by drle_front, drle_queue, drle_back and the top level; no dependencies.
`timescale 1ns / 1ps

package drle_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int VALUE_W     = 10;
    localparam int RUN_W       = 6;
    localparam int WORD_W      = VALUE_W + RUN_W;
    localparam int QUANT_MUL_W = 7;
    localparam int PROD_W      = SAMPLE_W + QUANT_MUL_W;
    localparam int QUANT_SHIFT = 10;

    localparam logic [QUANT_MUL_W-1:0] QUANT_MUL = 7'd104;
    localparam logic [VALUE_W-1:0]     VALUE_MAX = 10'd1023;
    localparam logic [RUN_W-1:0]       MAX_REPEATS = 6'd32;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One quantized item as handed from front to back
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } queue_entry_t;

    // One result word with its flags
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              image_end;
        logic              last_result;
    } result_t;

    // Handshake status of the queue seen by both neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[design/drle_front.sv]
// Front part: quantizes each depth sample and pushes it into the queue.
// Depends on drle_pkg.
`timescale 1ns / 1ps

module drle_front
(
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic [drle_pkg::SAMPLE_W-1:0]     depth_sample,
    input  logic                              image_last,
    input  drle_pkg::queue_status_t           status,
    output logic                              push,
    output drle_pkg::queue_entry_t            push_entry
);

    logic [drle_pkg::PROD_W-1:0]                    product;
    logic [drle_pkg::PROD_W-drle_pkg::QUANT_SHIFT-1:0] scaled;

    // Scale by 104/1024 and saturate to the value field
    always_comb
    begin
        product = drle_pkg::PROD_W'(depth_sample) * drle_pkg::PROD_W'(drle_pkg::QUANT_MUL);
        scaled  = product[drle_pkg::PROD_W-1:drle_pkg::QUANT_SHIFT];
        if (scaled > (drle_pkg::PROD_W-drle_pkg::QUANT_SHIFT)'(drle_pkg::VALUE_MAX))
        begin
            push_entry.value = drle_pkg::VALUE_MAX;
        end
        else
        begin
            push_entry.value = scaled[drle_pkg::VALUE_W-1:0];
        end
        push_entry.last = image_last;
    end

    // Hold the sender while the queue is full
    assign sample_stall = status.full;
    assign push         = sample_valid && !status.full;

endmodule

[design/drle_queue.sv]
// Short FIFO of quantized items between the front and back parts.
// Depends on drle_pkg.
`timescale 1ns / 1ps

module drle_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  drle_pkg::queue_entry_t  push_entry,
    input  logic                    pop,
    output drle_pkg::queue_entry_t  head_entry,
    output drle_pkg::queue_status_t status
);

    drle_pkg::queue_entry_t          mem_reg [drle_pkg::QUEUE_DEPTH];
    logic [drle_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [drle_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [drle_pkg::QUEUE_AW:0]     count_reg;
    logic [drle_pkg::QUEUE_AW:0]     count_next;

    // Write the entry at the tail
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head_entry   = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (drle_pkg::QUEUE_AW+1)'(drle_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

[design/drle_back.sv]
// Back part: keeps the open run, builds result words and drives the output.
// Depends on drle_pkg; takes items from drle_queue.
`timescale 1ns / 1ps

module drle_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  drle_pkg::queue_entry_t  head_entry,
    input  drle_pkg::queue_status_t status,
    output logic                    pop,
    output logic                    word_valid,
    input  logic                    word_stall,
    output drle_pkg::result_t       result
);

    logic [drle_pkg::VALUE_W-1:0] held_value_reg;
    logic [drle_pkg::VALUE_W-1:0] held_value_next;
    logic [drle_pkg::RUN_W-1:0]   repeat_count_reg;
    logic [drle_pkg::RUN_W-1:0]   repeat_count_next;
    logic                         holding_reg;
    logic                         holding_next;

    logic                         out_valid_reg;
    drle_pkg::result_t            out_reg;
    logic                         pend_valid_reg;
    drle_pkg::result_t            pend_reg;

    logic                         change;
    logic                         flush;
    logic [drle_pkg::VALUE_W-1:0] run_value;
    logic [drle_pkg::RUN_W-1:0]   run_count;
    drle_pkg::result_t            change_res;
    drle_pkg::result_t            flush_res;
    logic                         has_result;
    logic                         out_free;

    // Classify the head item against the open run
    always_comb
    begin
        change = holding_reg && (head_entry.value != held_value_reg);
        if (change || !holding_reg)
        begin
            run_value = head_entry.value;
            run_count = '0;
        end
        else
        begin
            run_value = held_value_reg;
            run_count = repeat_count_reg + 1'b1;
        end
        flush = (run_count >= drle_pkg::MAX_REPEATS) || head_entry.last;

        change_res.word        = {repeat_count_reg, held_value_reg};
        change_res.image_end   = 1'b0;
        change_res.last_result = !flush;

        flush_res.word         = {run_count, run_value};
        flush_res.image_end    = head_entry.last;
        flush_res.last_result  = 1'b1;

        if (flush)
        begin
            held_value_next   = '0;
            repeat_count_next = '0;
            holding_next      = 1'b0;
        end
        else
        begin
            held_value_next   = run_value;
            repeat_count_next = run_count;
            holding_next      = 1'b1;
        end
    end

    // Pop when every result of the item has a place to go
    assign out_free   = !out_valid_reg || !word_stall;
    assign has_result = change || flush;
    assign pop        = !status.empty && !pend_valid_reg && (!has_result || out_free);

    // Update the open run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_value_reg   <= '0;
            repeat_count_reg <= '0;
            holding_reg      <= 1'b0;
        end
        else if (pop)
        begin
            held_value_reg   <= held_value_next;
            repeat_count_reg <= repeat_count_next;
            holding_reg      <= holding_next;
        end
    end

    // Load the output register, parking a second word when an item gives two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (pop && has_result)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= change && flush;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output and parked words
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
            end
            else if (pop && has_result)
            begin
                out_reg <= change ? change_res : flush_res;
                pend_reg <= flush_res;
            end
        end
    end

    assign word_valid = out_valid_reg;
    assign result     = out_reg;

endmodule

[design/depth_run_length_encoder_core.sv]
// Depth run-length encoder top level: ties the front, queue and back parts.
// Depends on drle_pkg, drle_front, drle_queue and drle_back.
//
// Usage:
//   Input channel: sample_valid / sample_stall with depth_sample and
//   image_last. An item is taken at a clock edge where sample_valid is high
//   and sample_stall is low. Each sample is scaled by 104/1024 and clipped
//   to 1023, then merged into runs of equal values.
//   Output channel: word_valid / word_stall with code_word (value in bits
//   9:0, extra repeats in bits 15:10), image_end and last_result.
//   A word caused by an item passes through the queue and then the output
//   register before it is on the ports. The encoder takes one item per cycle
//   while each item gives at most one word and the queue is not full; an item
//   giving two words (value change that also closes the run) parks its second
//   word and holds the back part until that word has moved to the output.
//   A four-entry queue between the quantizer and the run logic absorbs
//   short output stalls; sample_stall rises only when that queue is full.
//   When the receiver stalls, the current word holds steady on the ports.
//   Reset (rst_n low, asynchronous) clears the open run and empties the
//   queue and output; no item is held afterwards.
`timescale 1ns / 1ps

module depth_run_length_encoder_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [drle_pkg::SAMPLE_W-1:0] depth_sample,
    input  logic                          image_last,
    output logic                          word_valid,
    input  logic                          word_stall,
    output logic [drle_pkg::WORD_W-1:0]   code_word,
    output logic                          image_end,
    output logic                          last_result
);

    logic                    push;
    logic                    pop;
    drle_pkg::queue_entry_t  push_entry;
    drle_pkg::queue_entry_t  head_entry;
    drle_pkg::queue_status_t status;
    drle_pkg::result_t       result;

    drle_front u_front
    (
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .depth_sample (depth_sample),
        .image_last   (image_last),
        .status       (status),
        .push         (push),
        .push_entry   (push_entry)
    );

    drle_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (status)
    );

    drle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .status     (status),
        .pop        (pop),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .result     (result)
    );

    // Split the result onto its ports
    assign code_word   = result.word;
    assign image_end   = result.image_end;
    assign last_result = result.last_result;

endmodule

[sim/tb_depth_run_length_encoder_core.sv]
// Self-checking testbench for depth_run_length_encoder_core: directed table, then random images.
// Depends on drle_pkg and the encoder RTL; predicts untyped words with its own run tracker, typed ones from the table.
`timescale 1ns / 1ps

module tb_depth_run_length_encoder_core;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1080;
    localparam int DRAIN_CYCLES = 16;
    localparam int NUM_ROWS     = 21;

    // One directed row: repeat count, item, and typed words (-1 = use the predictor)
    typedef struct packed {
        int                            reps;
        logic [drle_pkg::SAMPLE_W-1:0] sample;
        logic                          last;
        int                            n_typed;
        logic [drle_pkg::WORD_W-1:0]   word0;
        logic                          end0;
        logic [drle_pkg::WORD_W-1:0]   word1;
        logic                          end1;
    } stim_row_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    logic [drle_pkg::SAMPLE_W-1:0] depth_sample = '0;
    logic                          image_last   = 1'b0;
    logic                          word_valid;
    logic                          word_stall   = 1'b0;
    logic [drle_pkg::WORD_W-1:0]   code_word;
    logic                          image_end;
    logic                          last_result;

    // Predictor state: the open run
    logic [drle_pkg::VALUE_W-1:0]  run_value = '0;
    logic [drle_pkg::RUN_W-1:0]    run_extra = '0;
    logic                          run_open  = 1'b0;

    drle_pkg::result_t   pending_words [$];
    drle_pkg::result_t   step_words [$];
    drle_pkg::result_t   want;
    int                  error_count    = 0;
    int                  cycle_count    = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;

    stim_row_t dir_rows [NUM_ROWS] = '{
        '{1, 16'd0,     1'b1,  1, 16'h0000, 1'b1, 16'h0000, 1'b0}, // single-sample image
        '{1, 16'hFFFF,  1'b1,  1, 16'h03FF, 1'b1, 16'h0000, 1'b0}, // saturated maximum
        '{1, 16'd10083, 1'b0,  0, 16'h0000, 1'b0, 16'h0000, 1'b0}, // opens 1023
        '{1, 16'd10072, 1'b0, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1, 16'd10073, 1'b0, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1, 16'hFFFF,  1'b0,  0, 16'h0000, 1'b0, 16'h0000, 1'b0}, // extends 1023
        '{1, 16'd0,     1'b1,  2, 16'h07FF, 1'b0, 16'h0000, 1'b1}, // change plus end
        '{1, 16'd9,     1'b0, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1, 16'd10,    1'b0, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1, 16'd20,    1'b0, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1, 16'd19,    1'b1, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{32, 16'd10000, 1'b0, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1, 16'd10000, 1'b0,  1, 16'h83F7, 1'b0, 16'h0000, 1'b0}, // full run
        '{1, 16'd10000, 1'b1,  1, 16'h03F7, 1'b1, 16'h0000, 1'b0}, // same value, new run
        '{32, 16'd5000, 1'b0, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1, 16'd5000,  1'b1,  1, 16'h81FB, 1'b1, 16'h0000, 1'b0}, // full run at image end
        '{1, 16'd1000,  1'b0, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1, 16'd2000,  1'b0, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1, 16'd2000,  1'b1,  1, 16'h04CB, 1'b1, 16'h0000, 1'b0},
        '{1, 16'hAAAA,  1'b0, -1, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{1, 16'h5555,  1'b1, -1, 16'h0000, 1'b0, 16'h0000, 1'b0}
    };

    depth_run_length_encoder_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .depth_sample (depth_sample),
        .image_last   (image_last),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .code_word    (code_word),
        .image_end    (image_end),
        .last_result  (last_result)
    );

    // Toggle the clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Scale by 104/1024 and clip to the value field
    function automatic logic [drle_pkg::VALUE_W-1:0] quantize(
        input logic [drle_pkg::SAMPLE_W-1:0] s);
        logic [drle_pkg::PROD_W-1:0] prod;
        prod = s * drle_pkg::QUANT_MUL;
        prod = prod >> drle_pkg::QUANT_SHIFT;
        if (prod > drle_pkg::VALUE_MAX)
            return drle_pkg::VALUE_MAX;
        return prod[drle_pkg::VALUE_W-1:0];
    endfunction

    // Advance the run tracker by one item; leave its words in step_words
    task automatic encode_sample(input logic [drle_pkg::SAMPLE_W-1:0] s, input logic l);
        logic [drle_pkg::VALUE_W-1:0] q;
        drle_pkg::result_t            words [2];
        int                           n;
        q = quantize(s);
        n = 0;
        step_words.delete();
        if (run_open && q != run_value)
        begin
            words[n] = '{word: {run_extra, run_value}, image_end: 1'b0, last_result: 1'b0};
            n++;
            run_open = 1'b0;
        end
        if (run_open)
            run_extra = run_extra + 1'b1;
        else
        begin
            run_value = q;
            run_extra = '0;
            run_open  = 1'b1;
        end
        // Close the run when full or at the end of the image
        if (run_extra >= drle_pkg::MAX_REPEATS || l)
        begin
            words[n] = '{word: {run_extra, run_value}, image_end: l, last_result: 1'b0};
            n++;
            run_open  = 1'b0;
            run_value = '0;
            run_extra = '0;
        end
        if (n > 0)
            words[n-1].last_result = 1'b1;
        for (int i = 0; i < n; i++)
            step_words.push_back(words[i]);
    endtask

    // Offer one item, hold it until taken, then record its predicted words unless typed
    task automatic feed_sample(input logic [drle_pkg::SAMPLE_W-1:0] s, input logic l,
                               input bit typed);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        depth_sample <= s;
        image_last   <= l;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        encode_sample(s, l);
        if (!typed)
        begin
            foreach (step_words[i])
                pending_words.push_back(step_words[i]);
        end
    endtask

    // Hold the sender off until every predicted word has come out
    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // Send mostly well-formed images built from runs, with some loose items
    task automatic run_random(input int n_items);
        int                            sent;
        int                            roll;
        int                            img_len;
        int                            run_len;
        int                            pos;
        int                            k;
        logic [drle_pkg::SAMPLE_W-1:0] base;
        logic [drle_pkg::SAMPLE_W-1:0] s;
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                s = (roll < 5) ? drle_pkg::SAMPLE_W'($urandom)
                               : drle_pkg::SAMPLE_W'($urandom_range(0, 10000));
                feed_sample(s, $urandom_range(0, 3) == 0, 1'b0);
                sent++;
            end
            else
            begin
                img_len = $urandom_range(1, 90);
                pos = 0;
                while (pos < img_len)
                begin
                    base = ($urandom_range(0, 9) < 8)
                         ? drle_pkg::SAMPLE_W'($urandom_range(0, 10000))
                         : drle_pkg::SAMPLE_W'($urandom);
                    run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40)
                                                          : $urandom_range(1, 10);
                    k = 0;
                    while (k < run_len && pos < img_len)
                    begin
                        // Jitter the raw sample but keep it in the same quantum
                        s = base + drle_pkg::SAMPLE_W'($urandom_range(0, 9));
                        if (quantize(s) != quantize(base))
                            s = base;
                        feed_sample(s, pos == img_len - 1, 1'b0);
                        pos++;
                        sent++;
                        k++;
                    end
                end
            end
        end
    endtask

    // Stall the output at the phase's rate
    always @(posedge clk)
        word_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Check each taken word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && word_valid && !word_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got %h", $time, code_word);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (code_word !== want.word)
                begin
                    $display("%0t: code_word expected %h got %h", $time, want.word, code_word);
                    error_count++;
                end
                if (image_end !== want.image_end)
                begin
                    $display("%0t: image_end expected %b got %b",
                             $time, want.image_end, image_end);
                    error_count++;
                end
                if (last_result !== want.last_result)
                begin
                    $display("%0t: last_result expected %b got %b",
                             $time, want.last_result, last_result);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("depth_run_length_encoder_core test failed");
            $finish;
        end
    end

    // Reset, directed rows, then four random phases
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            for (int i = 0; i < dir_rows[r].reps; i++)
                feed_sample(dir_rows[r].sample, dir_rows[r].last, dir_rows[r].n_typed >= 0);
            if (dir_rows[r].n_typed == 1)
                pending_words.push_back('{word: dir_rows[r].word0,
                                          image_end: dir_rows[r].end0, last_result: 1'b1});
            if (dir_rows[r].n_typed == 2)
            begin
                pending_words.push_back('{word: dir_rows[r].word0,
                                          image_end: dir_rows[r].end0, last_result: 1'b0});
                pending_words.push_back('{word: dir_rows[r].word1,
                                          image_end: dir_rows[r].end1, last_result: 1'b1});
            end
        end
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            run_random(RANDOM_ITEMS / 4);
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_words.size() == 0)
            $display("depth_run_length_encoder_core test passed");
        else
            $display("depth_run_length_encoder_core test failed");
        $finish;
    end

endmodule
